// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate implication on the same edge
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked on the following edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ptt_pkg.sv -----
`default_nettype none

package ptt_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LOOK,
    S_STAMP,
    S_MIN,
    S_EXP,
    S_DONE
  } state_t;

  localparam logic [2:0] FN_ADD      = 3'd0;
  localparam logic [2:0] FN_LOOKUP   = 3'd1;
  localparam logic [2:0] FN_TICK     = 3'd2;
  localparam logic [2:0] FN_EXP_AGED = 3'd3;
  localparam logic [2:0] FN_EXP_ALL  = 3'd4;
  localparam logic [2:0] FN_RESTAMP  = 3'd5;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EXPIRED   = 2'd3;

  localparam logic       REG_TIMEOUT     = 1'b0;
  localparam logic [30:0] TIMEOUT_DEFAULT = 31'd45;
  localparam logic [30:0] TIMEOUT_NEVER   = 31'h7fffffff;

endpackage

`default_nettype wire

// ----- rtl/ptt_ram.sv -----
`default_nettype none

module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/pending_transaction_table_unit.sv -----
`default_nettype none
// Pending transaction table.
// Requests enter on start/func/session_handle/trx_id/any_handle/any_id and are
// taken when start is high and busy is low. busy stays high until the last
// result of the request has been driven. Results appear at most one per cycle on
// status/slot/found_handle/found_id/min_remaining/last, each for a single cycle
// under done; the final result of a request has last set. Expire requests give
// one result per removed entry, in slot order, then a closing result.
// Each request walks the table: add to the first free slot, lookup to the first
// match, restamp over every slot; then a minimum-remaining pass, and for expire
// a removal pass, before the final result. The next request may already be
// taken while that final result is on the outputs.
// The table is walked one slot per cycle through the single read port of the
// entry memories; one subtract and compare unit serves every slot.
// timeout_ticks sits at byte address 0 of the APB port; writing 0 stores 45.
// Reset empties the table, clears the tick counter and sets the timeout to 45;
// no clearing pass runs, the unit is ready as soon as reset drops.
// Results cannot be held off by the receiver.
`include "assert_macros.svh"

module pending_transaction_table_unit
  import ptt_pkg::*;
#(
  parameter int SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func,
  input  wire logic [63:0] session_handle,
  input  wire logic [63:0] trx_id,
  input  wire logic        any_handle,
  input  wire logic        any_id,
  output logic             done,
  output logic [1:0]       status,
  output logic [5:0]       slot,
  output logic [63:0]      found_handle,
  output logic [63:0]      found_id,
  output logic [30:0]      min_remaining,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic [CW-1:0]     idx;
  logic              p_vld;
  logic [IW-1:0]     p_idx;
  logic [SLOTS-1:0]  valid;
  logic [31:0]       tick_now;
  logic [30:0]       timeout;
  logic [30:0]       best;

  logic [2:0]        func_r;
  logic [63:0]       h_r;
  logic [63:0]       id_r;
  logic              anyh_r;
  logic              anyi_r;
  logic [1:0]        status_r;
  logic [5:0]        slot_r;
  logic [63:0]       fh_r;
  logic [63:0]       fid_r;

  logic [127:0]      hid_q;
  logic [31:0]       stamp_q;

  logic              hid_we;
  logic              stamp_we;
  logic [31:0]       stamp_wdata;
  logic              issue;
  logic              res_fire;
  logic [1:0]        res_status;
  logic [5:0]        res_slot;
  logic [63:0]       res_handle;
  logic [63:0]       res_id;
  logic              res_last;
  logic [30:0]       mr_out;

  logic              accept;
  logic              cfg_write;
  logic [IW-1:0]     idx_i;
  logic              idx_end;
  logic              p_end;
  logic              valid_p;
  logic              valid_i;
  logic [31:0]       age;
  logic [32:0]       rem;
  logic              rem_pos;
  logic              match;
  logic              expire_hit;
  logic              is_expire;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_TIMEOUT) ? {1'b0, timeout} : 32'd0;

  assign idx_i   = idx[IW-1:0];
  assign idx_end = (idx == CW'(SLOTS - 1));
  assign p_end   = p_vld && (p_idx == IW'(SLOTS - 1));
  assign valid_p = valid[p_idx];
  assign valid_i = valid[idx_i];

  assign age        = tick_now - stamp_q;
  assign rem        = {2'b00, timeout} - {1'b0, age};
  assign rem_pos    = !rem[32] && (rem != 33'd0);
  assign match      = valid_p && (anyh_r || (hid_q[127:64] == h_r)) &&
                      (anyi_r || (hid_q[63:0] == id_r));
  assign expire_hit = valid_p && ((func_r == FN_EXP_ALL) ||
                      ((timeout != TIMEOUT_NEVER) && (age >= {1'b0, timeout})));
  assign is_expire  = (func_r == FN_EXP_AGED) || (func_r == FN_EXP_ALL);
  assign mr_out     = (func_r == FN_EXP_ALL) ? TIMEOUT_NEVER : best;

  ptt_ram #(.WIDTH(128), .DEPTH(SLOTS)) u_hid_ram (
    .clk   (clk),
    .we    (hid_we),
    .waddr (idx_i),
    .wdata ({h_r, id_r}),
    .raddr (idx_i),
    .rdata (hid_q)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (idx_i),
    .wdata (stamp_wdata),
    .raddr (idx_i),
    .rdata (stamp_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func)
            FN_ADD:     state_next = S_ADD;
            FN_LOOKUP:  state_next = S_LOOK;
            FN_RESTAMP: state_next = S_STAMP;
            default:    state_next = S_MIN;
          endcase
        end
      end
      S_ADD: begin
        if (!valid_i || idx_end) begin
          state_next = S_MIN;
        end
      end
      S_LOOK: begin
        if (p_vld && (match || p_end)) begin
          state_next = S_MIN;
        end
      end
      S_STAMP: begin
        if (idx_end) begin
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        if (p_end) begin
          state_next = is_expire ? S_EXP : S_DONE;
        end
      end
      S_EXP: begin
        if (p_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hid_we      = 1'b0;
    stamp_we    = 1'b0;
    stamp_wdata = tick_now;
    issue       = 1'b0;
    res_fire    = 1'b0;
    res_status  = ST_DONE;
    res_slot    = 6'd0;
    res_handle  = 64'd0;
    res_id      = 64'd0;
    res_last    = 1'b0;
    case (state)
      S_ADD: begin
        hid_we   = !valid_i;
        stamp_we = !valid_i;
      end
      S_LOOK: begin
        issue = (idx < CW'(SLOTS)) && !(p_vld && match);
      end
      S_STAMP: begin
        stamp_we = valid_i;
      end
      S_MIN: begin
        issue = (idx < CW'(SLOTS)) && !p_end;
      end
      S_EXP: begin
        issue = (idx < CW'(SLOTS)) && !p_end;
        if (p_vld && expire_hit) begin
          res_fire   = 1'b1;
          res_status = ST_EXPIRED;
          res_slot   = 6'(p_idx);
          res_handle = hid_q[127:64];
          res_id     = hid_q[63:0];
        end
      end
      S_DONE: begin
        res_fire   = 1'b1;
        res_status = status_r;
        res_slot   = slot_r;
        res_handle = fh_r;
        res_id     = fid_r;
        res_last   = 1'b1;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      p_vld    <= 1'b0;
      valid    <= '0;
      tick_now <= 32'd0;
      timeout  <= TIMEOUT_DEFAULT;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      p_vld <= issue;
      p_idx <= idx_i;
      done  <= res_fire;

      if (state_next != state) begin
        idx <= '0;
      end else if (issue || (state == S_ADD) || (state == S_STAMP)) begin
        idx <= idx + CW'(1);
      end

      if (cfg_write && (paddr[2] == REG_TIMEOUT)) begin
        timeout <= (pwdata[30:0] != 31'd0) ? pwdata[30:0] : TIMEOUT_DEFAULT;
      end

      if (accept && (func == FN_TICK)) begin
        tick_now <= tick_now + 32'd1;
      end

      if ((state == S_ADD) && !valid_i) begin
        valid[idx_i] <= 1'b1;
      end
      if ((state == S_LOOK) && p_vld && match) begin
        valid[p_idx] <= 1'b0;
      end
      if ((state == S_EXP) && p_vld && expire_hit) begin
        valid[p_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func;
      h_r      <= session_handle;
      id_r     <= trx_id;
      anyh_r   <= any_handle;
      anyi_r   <= any_id;
      status_r <= ST_DONE;
      slot_r   <= 6'd0;
      fh_r     <= 64'd0;
      fid_r    <= 64'd0;
      best     <= TIMEOUT_NEVER;
    end

    case (state)
      S_ADD: begin
        if (!valid_i) begin
          slot_r <= 6'(idx_i);
        end else if (idx_end) begin
          status_r <= ST_FULL;
        end
      end
      S_LOOK: begin
        if (p_vld && match) begin
          slot_r <= 6'(p_idx);
          fh_r   <= hid_q[127:64];
          fid_r  <= hid_q[63:0];
        end else if (p_end) begin
          status_r <= ST_NOT_FOUND;
        end
      end
      S_MIN: begin
        if (p_vld && valid_p && rem_pos && (rem[30:0] < best)) begin
          best <= rem[30:0];
        end
      end
      default: ;
    endcase

    status        <= res_status;
    slot          <= res_slot;
    found_handle  <= res_handle;
    found_id      <= res_id;
    min_remaining <= mr_out;
    last          <= res_last;
  end

  `ASSERT_SAME(a_last_ends_run, clk, rst, done && last, state == S_IDLE)
  `ASSERT_SAME(a_mid_is_expired, clk, rst, done && !last, status == ST_EXPIRED)
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_SAME(a_idle_no_read, clk, rst, !busy, !p_vld)

endmodule

`default_nettype wire
